// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define BCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define BCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg
// Sizes, status codes and controller/datapath interface types for the
// bitmap contiguous allocator.
// ----------------------------------------------------------------------------
package bca_pkg;

  // Geometry of the occupancy map and the owner table.
  localparam int MEM_BLOCKS    = 32;
  localparam int TABLE_ENTRIES = 32;

  // Fixed field widths of the request and result transfers.
  localparam int ID_W     = 16;
  localparam int LEN_W    = 6;
  localparam int START_W  = 5;
  localparam int STATUS_W = 2;

  // Derived internal widths.
  localparam int BLK_W = $clog2(MEM_BLOCKS);
  localparam int ENT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int RUN_W = $clog2(MEM_BLOCKS + 1);
  localparam int SUM_W = ((BLK_W > LEN_W) ? BLK_W : LEN_W) + 1;

  // Request codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_NOT_FOUND  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;          // capture the request and clear the search state
    logic    scan_step;     // examine one map block
    logic    commit_alloc;  // record the entry and mark the run used
    logic    tbl_read;      // read the table entry at the search index
    logic    tbl_next;      // advance the table search index
    logic    commit_free;   // kill the entry and mark its run free
    logic    finish;        // latch the result
    status_t res_status;    // status of the latched result
    logic    push;          // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;    // requested length is zero
    logic scan_hit;    // current block completes a long enough run
    logic scan_last;   // current block is the last one in the map
    logic table_full;  // no table slot is left
    logic tbl_done;    // search index has passed all used entries
    logic tbl_hit;     // entry just read is live and owned by the ID
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== src/bca_ctrl.sv =====
// ----------------------------------------------------------------------------
// bca_ctrl
// Sequencer for the allocator: runs the map scan for allocate and the
// table search for free, then hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bca_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_cmd,
  output logic               in_stall,
  input  bca_pkg::dp_stat_t  stat,
  output bca_pkg::dp_cmd_t   cmd
);
  import bca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TBL_RD,
    S_TBL_CMP,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  // Requests are taken only between operations, never during reset.
  assign in_stall = !rst_n || (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_cmd == CMD_FREE) ? S_TBL_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.len_zero) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_NO_SPACE;
          state_nxt      = S_RESP;
        end else if (stat.scan_hit) begin
          cmd.finish = 1'b1;
          if (stat.table_full) begin
            cmd.res_status = ST_TABLE_FULL;
          end else begin
            cmd.commit_alloc = 1'b1;
            cmd.res_status   = ST_OK;
          end
          state_nxt = S_RESP;
        end else if (stat.scan_last) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_NO_SPACE;
          state_nxt      = S_RESP;
        end
      end
      S_TBL_RD: begin
        if (stat.tbl_done) begin
          cmd.finish     = 1'b1;
          cmd.res_status = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          cmd.tbl_read = 1'b1;
          state_nxt    = S_TBL_CMP;
        end
      end
      S_TBL_CMP: begin
        if (stat.tbl_hit) begin
          cmd.commit_free = 1'b1;
          cmd.finish      = 1'b1;
          cmd.res_status  = ST_OK;
          state_nxt       = S_RESP;
        end else begin
          cmd.tbl_next = 1'b1;
          state_nxt    = S_TBL_RD;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BCA_ASSERT_NEXT(a_accept_dispatch, state_r == S_IDLE && in_valid, state_r == S_SCAN || state_r == S_TBL_RD, "accepted request did not start an operation")
  `BCA_ASSERT(a_push_free, cmd.push |-> stat.out_free, "result pushed into a full output register")
  `BCA_ASSERT_NEXT(a_resp_hold, state_r == S_RESP && !stat.out_free, state_r == S_RESP, "result dropped while the output register was full")

endmodule

// ===== src/bca_datapath.sv =====
// ----------------------------------------------------------------------------
// bca_datapath
// Occupancy map, owner table memory, search counters and the output
// register of the allocator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bca_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_cmd,
  input  logic [bca_pkg::ID_W-1:0]          in_owner_id,
  input  logic [bca_pkg::LEN_W-1:0]         in_run_length,
  input  bca_pkg::dp_cmd_t                  cmd,
  output bca_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bca_pkg::STATUS_W-1:0]      out_status,
  output logic [bca_pkg::START_W-1:0]       out_start_block
);
  import bca_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]  owner;
    logic [BLK_W-1:0] start;
    logic [LEN_W-1:0] size;
  } entry_t;

  // Request registers.
  logic              req_cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [LEN_W-1:0]  len_r;

  // Persistent state.
  logic [MEM_BLOCKS-1:0]    map_r;
  logic [TABLE_ENTRIES-1:0] live_r;
  logic [CNT_W-1:0]         used_r;
  entry_t                   tbl_mem [TABLE_ENTRIES];
  entry_t                   rd_q;

  // Search state.
  logic [BLK_W-1:0] scan_idx_r;
  logic [RUN_W-1:0] run_r;
  logic [BLK_W-1:0] run_start_r;
  logic [CNT_W-1:0] tbl_idx_r;

  // Result and output registers.
  status_t             res_status_r;
  logic [START_W-1:0]  res_start_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [START_W-1:0]  out_start_r;

  logic [ENT_W-1:0]      tbl_addr;
  logic [ENT_W-1:0]      used_addr;
  logic                  blk_free;
  logic [BLK_W-1:0]      cand_start;
  logic [BLK_W-1:0]      mask_lo;
  logic [LEN_W-1:0]      mask_len;
  logic [MEM_BLOCKS-1:0] run_mask;

  assign tbl_addr  = tbl_idx_r[ENT_W-1:0];
  assign used_addr = used_r[ENT_W-1:0];

  // A new run starts at the current block when no free run is open.
  assign blk_free   = !map_r[scan_idx_r];
  assign cand_start = (run_r == '0) ? scan_idx_r : run_start_r;

  // Status toward the controller.
  always_comb begin
    stat            = '0;
    stat.len_zero   = (len_r == '0);
    stat.scan_hit   = blk_free && (len_r != '0) &&
                      ((SUM_W'(run_r) + SUM_W'(1)) >= SUM_W'(len_r));
    stat.scan_last  = (scan_idx_r == BLK_W'(MEM_BLOCKS - 1));
    stat.table_full = (used_r == CNT_W'(TABLE_ENTRIES));
    stat.tbl_done   = (tbl_idx_r >= used_r);
    stat.tbl_hit    = live_r[tbl_addr] && (rd_q.owner == id_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Block mask of the run being set or cleared; blocks past the map drop out.
  assign mask_lo  = cmd.commit_alloc ? cand_start : rd_q.start;
  assign mask_len = cmd.commit_alloc ? len_r : rd_q.size;

  always_comb begin
    for (int b = 0; b < MEM_BLOCKS; b++) begin
      run_mask[b] = (SUM_W'(b) >= SUM_W'(mask_lo)) &&
                    (SUM_W'(b) < (SUM_W'(mask_lo) + SUM_W'(mask_len)));
    end
  end

  // Map, live marks, fill count and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r       <= '0;
      live_r      <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit_alloc) begin
        map_r            <= map_r | run_mask;
        live_r[used_addr] <= 1'b1;
        used_r           <= used_r + CNT_W'(1);
      end else if (cmd.commit_free) begin
        map_r            <= map_r & ~run_mask;
        live_r[tbl_addr] <= 1'b0;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Owner table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit_alloc) begin
      tbl_mem[used_addr] <= '{owner: id_r, start: cand_start, size: len_r};
    end
    if (cmd.tbl_read) begin
      rd_q <= tbl_mem[tbl_addr];
    end
  end

  // Request capture and search counters.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd_r   <= in_cmd;
      id_r        <= in_owner_id;
      len_r       <= in_run_length;
      scan_idx_r  <= '0;
      run_r       <= '0;
      run_start_r <= '0;
      tbl_idx_r   <= '0;
    end else begin
      if (cmd.scan_step) begin
        if (blk_free) begin
          run_start_r <= cand_start;
          run_r       <= run_r + RUN_W'(1);
        end else begin
          run_r <= '0;
        end
        scan_idx_r <= scan_idx_r + BLK_W'(1);
      end
      if (cmd.tbl_next) begin
        tbl_idx_r <= tbl_idx_r + CNT_W'(1);
      end
    end
  end

  // Result latch and output register payload.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= cmd.res_status;
      if (cmd.commit_alloc) begin
        res_start_r <= START_W'(cand_start);
      end else if (cmd.commit_free) begin
        res_start_r <= START_W'(rd_q.start);
      end else begin
        res_start_r <= '0;
      end
    end
    if (cmd.push) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_r;

  `BCA_ASSERT_NEXT(a_used_incr, cmd.commit_alloc, used_r == $past(used_r) + CNT_W'(1), "fill count did not advance on allocate")
  `BCA_ASSERT(a_alloc_room, cmd.commit_alloc |-> (stat.scan_hit && !stat.table_full && req_cmd_r == CMD_ALLOC), "allocate committed without a run or a free slot")
  `BCA_ASSERT(a_free_hit, cmd.commit_free |-> (stat.tbl_hit && !stat.tbl_done && req_cmd_r == CMD_FREE), "free committed without a matching live entry")

endmodule

// ===== src/bitmap_contiguous_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_contiguous_allocator
// First-fit contiguous block allocator over a one-bit-per-block map, with
// an append-only owner table for releasing runs by ID.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   in_cmd, in_owner_id, in_run_length
//   out_      output     out_valid / out_stall out_status, out_start_block
//
// Allocate scans the map one block per cycle from transfer in to result ready.
// Free reads each owner table entry from memory and then compares it, entry
// by entry, until a match or the last used entry.
// Reset clears the map, the live marks and the fill count.
// A new request is taken while the previous result waits in the output
// register; a result is held there for as long as out_stall is high.
// ----------------------------------------------------------------------------
module bitmap_contiguous_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [bca_pkg::ID_W-1:0]     in_owner_id,
  input  logic [bca_pkg::LEN_W-1:0]    in_run_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bca_pkg::STATUS_W-1:0] out_status,
  output logic [bca_pkg::START_W-1:0]  out_start_block
);
  import bca_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  bca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Map, table and output register.
  bca_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_owner_id     (in_owner_id),
    .in_run_length   (in_run_length),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_start_block (out_start_block)
  );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap contiguous allocator. A queue of
// requests (a directed opening, then random allocate and free traffic over
// a small pool of owner IDs) is driven through the valid/stall input
// channel. A local model of the occupancy map and the owner table predicts
// each result, and the monitor compares every result transfer in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bca_pkg::*;

  // One request transfer, with bench-only control for pacing.
  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic              drain;  // hold off until every result has arrived
    logic [1:0]        phase;  // selects the idle mix on both sides
  } alloc_req_t;

  // One result transfer.
  typedef struct packed {
    status_t              status;
    logic [START_W-1:0]   start;
  } alloc_res_t;

  localparam int RAND_ITEMS  = 750;
  localparam int SETTLE_CYC  = 80;
  localparam int PHASE_ITEMS = RAND_ITEMS / 3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_ALLOC;
  logic [ID_W-1:0]      in_owner_id = '0;
  logic [LEN_W-1:0]     in_run_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [START_W-1:0]   out_start_block;

  alloc_req_t pending_reqs[$];
  alloc_res_t expected_results[$];
  alloc_req_t held_req;
  logic       in_fire = 1'b0;
  logic [1:0] cur_phase = 2'd0;
  int         err_cnt = 0;

  // Shadow copy of the allocator state.
  bit [MEM_BLOCKS-1:0] blk_used;
  bit [ID_W-1:0]       tbl_owner [TABLE_ENTRIES];
  bit [START_W-1:0]    tbl_start [TABLE_ENTRIES];
  bit [LEN_W-1:0]      tbl_len   [TABLE_ENTRIES];
  bit                  tbl_live  [TABLE_ENTRIES];
  int                  tbl_fill;

  bitmap_contiguous_allocator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_owner_id    (in_owner_id),
    .in_run_length  (in_run_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_start_block(out_start_block)
  );

  // Clock and a single reset pulse.
  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Percentage of cycles in which the sender stays idle.
  function automatic int sender_idle_pct(logic [1:0] ph);
    case (ph)
      2'd0: sender_idle_pct = 34;
      2'd1: sender_idle_pct = 85;
      default: sender_idle_pct = 0;
    endcase
  endfunction

  // Percentage of cycles in which the receiver stalls.
  function automatic int receiver_stall_pct(logic [1:0] ph);
    case (ph)
      2'd0: receiver_stall_pct = 85;
      2'd1: receiver_stall_pct = 34;
      default: receiver_stall_pct = 0;
    endcase
  endfunction

  // First-fit allocate or release by owner; updates the shadow state and
  // returns the result the block must produce for this request.
  function automatic alloc_res_t predict_alloc_result(alloc_req_t r);
    alloc_res_t res;
    int         run_len;
    int         run_first;
    int         b;
    int         e;
    int         k;
    bit         found;
    bit         done;
    res.status = ST_NO_SPACE;
    res.start  = '0;
    if (r.cmd == CMD_ALLOC) begin
      run_len   = 0;
      run_first = 0;
      found     = 1'b0;
      // A zero length never matches; longer than the map never completes.
      if (r.len != 0) begin
        for (b = 0; b < MEM_BLOCKS; b++) begin
          if (!found) begin
            if (!blk_used[b]) begin
              if (run_len == 0) run_first = b;
              run_len++;
              if (run_len >= r.len) found = 1'b1;
            end else begin
              run_len = 0;
            end
          end
        end
      end
      // The space search wins over a full table.
      if (found && tbl_fill >= TABLE_ENTRIES) begin
        res.status = ST_TABLE_FULL;
      end else if (found) begin
        tbl_owner[tbl_fill] = r.id;
        tbl_start[tbl_fill] = run_first[START_W-1:0];
        tbl_len[tbl_fill]   = r.len;
        tbl_live[tbl_fill]  = 1'b1;
        tbl_fill++;
        for (k = 0; k < r.len; k++) blk_used[run_first + k] = 1'b1;
        res.status = ST_OK;
        res.start  = run_first[START_W-1:0];
      end
    end else begin
      // Release the lowest-numbered live entry owned by this ID.
      res.status = ST_NOT_FOUND;
      done       = 1'b0;
      for (e = 0; e < tbl_fill; e++) begin
        if (!done && tbl_live[e] && tbl_owner[e] == r.id) begin
          done        = 1'b1;
          tbl_live[e] = 1'b0;
          for (k = 0; k < tbl_len[e]; k++) begin
            if (tbl_start[e] + k < MEM_BLOCKS) blk_used[tbl_start[e] + k] = 1'b0;
          end
          res.status = ST_OK;
          res.start  = tbl_start[e];
        end
      end
    end
    return res;
  endfunction

  // Build the request list: directed opening, then three random phases.
  initial begin
    logic [ID_W-1:0] id_pool [6];
    alloc_req_t      r;
    int              n;
    int              pick;
    // Opening: length extremes, full map, duplicate owners, dead entries.
    pending_reqs.push_back('{CMD_FREE,  16'h0000, 6'd63, 1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0000, 6'd0,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0001, 6'd33, 1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0002, 6'd63, 1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'hFFFF, 6'd32, 1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0003, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_FREE,  16'hFFFF, 6'd0,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h1234, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h1234, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h5555, 6'd5,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_FREE,  16'h1234, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'hAAAA, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_FREE,  16'h1234, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_FREE,  16'h1234, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0F0F, 6'd30, 1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'hF0F0, 6'd25, 1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0001, 6'd2,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_ALLOC, 16'h0001, 6'd1,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_FREE,  16'h5555, 6'd0,  1'b0, 2'd0});
    pending_reqs.push_back('{CMD_FREE,  16'hFFFF, 6'd0,  1'b0, 2'd0});
    // A small owner pool makes allocate/free pairs and duplicates common.
    for (n = 0; n < 6; n++) id_pool[n] = ID_W'($urandom_range(16'hFFFF));
    for (n = 0; n < RAND_ITEMS; n++) begin
      r.cmd   = ($urandom_range(99) < 50) ? CMD_ALLOC : CMD_FREE;
      r.id    = ($urandom_range(99) < 80) ? id_pool[$urandom_range(5)]
                                          : ID_W'($urandom_range(16'hFFFF));
      pick    = $urandom_range(99);
      if (pick < 75)      r.len = LEN_W'($urandom_range(6, 1));
      else if (pick < 90) r.len = LEN_W'($urandom_range(32, 7));
      else                r.len = LEN_W'($urandom_range(63));
      r.phase = (n / PHASE_ITEMS > 2) ? 2'd2 : 2'(n / PHASE_ITEMS);
      r.drain = (n % PHASE_ITEMS == 0) || ($urandom_range(99) < 2);
      pending_reqs.push_back(r);
    end
  end

  // Request side: register each accepted transfer and predict its result.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      expected_results.push_back(predict_alloc_result(held_req));
      in_fire <= 1'b1;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // Request driver: holds a stalled transfer, otherwise idles or sends next.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (pending_reqs.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending_reqs[0].drain && expected_results.size() != 0) begin
      in_valid <= 1'b0;
    end else if ($urandom_range(99) < sender_idle_pct(pending_reqs[0].phase)) begin
      in_valid <= 1'b0;
    end else begin
      held_req      = pending_reqs.pop_front();
      in_cmd        <= held_req.cmd;
      in_owner_id   <= held_req.id;
      in_run_length <= held_req.len;
      cur_phase     <= held_req.phase;
      in_valid      <= 1'b1;
    end
  end

  // Result side: random stall pattern following the current phase.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct(cur_phase));
  end

  // Result monitor: each transfer must match the oldest prediction.
  always @(posedge clk) begin
    alloc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got status %0d start %0d",
                 $realtime, out_status, out_start_block);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch, expected %s (%0d), got %0d",
                   $realtime, want.status.name(), want.status, out_status);
          err_cnt++;
        end
        if (out_start_block !== want.start) begin
          $display("%0t: start_block mismatch, expected %0d, got %0d",
                   $realtime, want.start, out_start_block);
          err_cnt++;
        end
      end
    end
  end

  // End of run: all requests sent, all results in, then let the block settle.
  initial begin
    @(posedge rst_n);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
